/* sv/assert_macros.svh */
// Assertion helpers for the SDO client RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rstn, ante, cons)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/sdo_pkg.sv */
package sdo_pkg;

  localparam int WRITE_STORE_DEPTH = 2048;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WR_EXP = 3'd1;
  localparam logic [2:0] OP_WR_SEG = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_REPLY  = 3'd4;
  localparam logic [2:0] OP_TMO    = 3'd5;

  localparam logic [3:0] ST_NONE    = 4'd0;
  localparam logic [3:0] ST_OK      = 4'd1;
  localparam logic [3:0] ST_TIMEOUT = 4'd2;
  localparam logic [3:0] ST_ABORT   = 4'd3;
  localparam logic [3:0] ST_LEN     = 4'd4;
  localparam logic [3:0] ST_OBJ     = 4'd5;
  localparam logic [3:0] ST_TOGGLE  = 4'd6;
  localparam logic [3:0] ST_SIZE    = 4'd7;
  localparam logic [3:0] ST_HEADER  = 4'd8;
  localparam logic [3:0] ST_SEGS    = 4'd9;
  localparam logic [3:0] ST_UNEXP   = 4'd10;

  localparam logic [1:0] CFG_NODE = 2'd0;
  localparam logic [1:0] CFG_MAXS = 2'd1;
  localparam logic [1:0] CFG_SPY  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RD_INIT, PH_RD_SEG, PH_WR_EXP, PH_WR_INIT, PH_WR_SEG
  } phase_t;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_OUT} ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic eval;     // accept item, evaluate, start a fetch if needed
    logic fetch;    // fetch one store byte
    logic finish;   // latch result into the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_fetch;
    logic fetch_last;
  } dp_sts_t;

endpackage

/* sv/sdo_ctrl.sv */
module sdo_ctrl
  import sdo_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    out_tready,
  output logic    out_tvalid,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  `include "assert_macros.svh"

  ctl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          state_nxt = sts.need_fetch ? S_FETCH : S_OUT;
        end
      end
      S_FETCH: begin
        if (sts.fetch_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.eval = in_tvalid;
      end
      S_FETCH: cmd.fetch = 1'b1;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `CHK_NEXT(a_hold, clk, rst_n, out_valid_r && !out_tready, out_valid_r)
  `CHK_IMPL(a_rdy, clk, rst_n, in_tready, state_r == S_IDLE)
  `CHK_NEXT(a_fin, clk, rst_n, cmd.finish, out_valid_r && state_r == S_IDLE)
endmodule

/* sv/sdo_dp.sv */
module sdo_dp
  import sdo_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  input  logic [2:0]    opcode,
  input  logic [15:0]   object_index,
  input  logic [7:0]    object_subindex,
  input  logic [31:0]   write_word,
  input  logic [2:0]    write_count,
  input  logic [11:0]   write_length,
  input  logic [10:0]   load_position,
  input  logic [7:0]    load_byte,
  input  logic [63:0]   reply_bytes,
  input  logic [3:0]    reply_length,
  input  logic [6:0]    node_id,
  input  logic [15:0]   max_segments,
  input  logic          spy_mode,
  output logic [172:0]  result
);
  localparam int DEPTH = WRITE_STORE_DEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  phase_t      phase_r, phase_nxt;
  logic        toggle_r, toggle_nxt;
  logic [15:0] segs_r, segs_nxt;
  logic [15:0] hidx_r, hidx_nxt;
  logic [7:0]  hsub_r, hsub_nxt;
  logic [11:0] total_r, total_nxt;
  logic [11:0] sent_r, sent_nxt;

  logic [7:0] store [DEPTH];
  logic [7:0] rd_q;

  logic        sv, rv, dn;
  logic [63:0] sb;
  logic [55:0] rd;
  logic [2:0]  rc;
  logic [3:0]  st;
  logic [31:0] ab;
  logic        fetch_req;

  // pending result during a store fetch
  logic        p_sv_r, p_rv_r, p_dn_r;
  logic [63:0] p_sb_r;
  logic [55:0] p_rd_r;
  logic [2:0]  p_rc_r;
  logic [3:0]  p_st_r;
  logic [31:0] p_ab_r;
  logic [2:0]  f_n_r, f_i_r, f_j_r;
  logic        f_rd_r;
  logic [11:0] f_base_r;
  logic [11:0] f_base;
  logic [2:0]  f_n;
  logic [11:0] f_pos;
  logic [172:0] out_r;

  logic [11:0] left;
  logic [11:0] left_seg;
  logic [2:0]  n_oct;
  logic [11:0] sent_adv;
  logic [7:0]  b0;
  logic [23:0] objf;
  logic [11:0] len_c;
  logic [2:0]  n_exp;
  logic [15:0] segs_inc;

  assign objf = {hsub_r, hidx_r};
  assign b0 = reply_bytes[7:0];

  always_comb begin
    left = (total_r > sent_r) ? total_r - sent_r : 12'd0;
    n_oct = (left < 12'd7) ? left[2:0] : 3'd7;
    sent_adv = sent_r + {9'd0, n_oct};
    left_seg = (total_r > sent_adv) ? total_r - sent_adv : 12'd0;
  end

  always_comb begin
    phase_nxt = phase_r; toggle_nxt = toggle_r; segs_nxt = segs_r;
    hidx_nxt = hidx_r; hsub_nxt = hsub_r; total_nxt = total_r; sent_nxt = sent_r;
    sv = 1'b0; rv = 1'b0; dn = 1'b0; sb = '0; rd = '0; rc = '0; st = ST_NONE; ab = '0;
    fetch_req = 1'b0; f_base = sent_r; f_n = n_oct;
    len_c = (write_length > 12'(DEPTH)) ? 12'(DEPTH) : write_length;
    n_exp = (write_count < 3'd1) ? 3'd1 : ((write_count > 3'd4) ? 3'd4 : write_count);
    segs_inc = segs_r + 16'd1;
    if (opcode <= OP_WR_SEG && phase_r == PH_IDLE) begin
      hidx_nxt = object_index; hsub_nxt = object_subindex;
      toggle_nxt = 1'b0; segs_nxt = '0; sent_nxt = '0;
      if (opcode == OP_READ) begin
        sb = {32'd0, object_subindex, object_index, 8'h40}; sv = 1'b1;
        phase_nxt = PH_RD_INIT;
      end else if (opcode == OP_WR_EXP) begin
        sb = {32'd0, object_subindex, object_index,
              8'h23 | {3'd0, 3'd4 - n_exp, 2'd0}};
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < n_exp) sb[32 + 8*i +: 8] = write_word[8*i +: 8];
        end
        sv = 1'b1; phase_nxt = PH_WR_EXP;
      end else begin
        if (len_c == 12'd0) begin
          dn = 1'b1; st = ST_HEADER;
        end else begin
          total_nxt = len_c;
          sb = {20'd0, len_c, object_subindex, object_index, 8'h21}; sv = 1'b1;
          phase_nxt = PH_WR_INIT;
        end
      end
    end else if (opcode == OP_TMO) begin
      if (phase_r != PH_IDLE) begin dn = 1'b1; st = ST_TIMEOUT; phase_nxt = PH_IDLE; end
    end else if (opcode == OP_REPLY && !spy_mode) begin
      if (phase_r == PH_IDLE) begin
        st = ST_UNEXP;
      end else if (b0 == 8'h80) begin
        st = ST_ABORT; ab = reply_bytes[63:32];
      end else if (reply_length != 4'd8) begin
        st = ST_LEN;
      end else if ((phase_r == PH_RD_INIT || phase_r == PH_WR_EXP || phase_r == PH_WR_INIT)
                   && reply_bytes[31:8] != objf) begin
        st = ST_OBJ;
      end else begin
        case (phase_r)
          PH_RD_INIT: begin
            if (b0[1]) begin
              if (!b0[0]) begin
                st = ST_SIZE;
              end else begin
                rc = 3'd4 - {1'b0, b0[3:2]};
                for (int i = 0; i < 4; i++) begin
                  if (3'(i) < rc) rd[8*i +: 8] = reply_bytes[32 + 8*i +: 8];
                end
                rv = 1'b1; st = ST_OK;
              end
            end else begin
              toggle_nxt = 1'b0; segs_nxt = '0;
              sb = 64'h60; sv = 1'b1; phase_nxt = PH_RD_SEG;
            end
          end
          PH_RD_SEG: begin
            if (b0[4] != toggle_r) begin
              st = ST_TOGGLE;
            end else begin
              rc = 3'd7 - b0[3:1];
              for (int i = 0; i < 7; i++) begin
                if (3'(i) < rc) rd[8*i +: 8] = reply_bytes[8 + 8*i +: 8];
              end
              rv = 1'b1; toggle_nxt = !toggle_r; segs_nxt = segs_inc;
              if (segs_inc >= max_segments) st = ST_SEGS;
              else if (b0[0]) st = ST_OK;
              else begin sb = {56'd0, 3'b011, !toggle_r, 4'h0}; sv = 1'b1; end
            end
          end
          PH_WR_EXP: st = (b0 == 8'h60) ? ST_OK : ST_HEADER;
          PH_WR_INIT: begin
            toggle_nxt = 1'b0; segs_nxt = '0; sent_nxt = '0;
            sb = {56'd0, 3'd0, 1'b0, 3'd7 - n_oct, left <= 12'd7};
            sv = 1'b1; phase_nxt = PH_WR_SEG;
            fetch_req = 1'b1; f_base = sent_r; f_n = n_oct;
          end
          default: begin
            if (b0 != {3'b001, toggle_r, 4'h0}) begin
              st = ST_HEADER;
            end else begin
              sent_nxt = sent_adv; toggle_nxt = !toggle_r; segs_nxt = segs_inc;
              if (segs_inc >= max_segments) st = ST_SEGS;
              else if (sent_adv >= total_r) st = ST_OK;
              else begin
                f_n = (left_seg < 12'd7) ? left_seg[2:0] : 3'd7;
                sb = {59'd0, !toggle_r, 3'd7 - f_n, left_seg <= 12'd7};
                sv = 1'b1; fetch_req = 1'b1; f_base = sent_adv;
              end
            end
          end
        endcase
      end
      if (st != ST_NONE && st != ST_UNEXP) begin dn = 1'b1; phase_nxt = PH_IDLE; end
    end
  end

  assign sts.need_fetch = fetch_req && (f_n != 3'd0);
  assign sts.fetch_last = f_rd_r && (f_j_r + 3'd1 == f_n_r) && (f_i_r == f_n_r);

  assign f_pos = f_base_r + {9'd0, f_i_r};

  // Store write and registered read; one byte is requested per cycle.
  always_ff @(posedge clk) begin
    if (cmd.eval && opcode == OP_LOAD && {1'b0, load_position} < 12'(DEPTH)) begin
      store[load_position[AW-1:0]] <= load_byte;
    end
    rd_q <= store[f_pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; toggle_r <= 1'b0; segs_r <= '0; hidx_r <= '0;
      hsub_r <= '0; total_r <= '0; sent_r <= '0; f_rd_r <= 1'b0;
      f_i_r <= '0; f_j_r <= '0;
    end else begin
      if (cmd.eval) begin
        phase_r <= phase_nxt; toggle_r <= toggle_nxt; segs_r <= segs_nxt;
        hidx_r <= hidx_nxt; hsub_r <= hsub_nxt; total_r <= total_nxt; sent_r <= sent_nxt;
        f_i_r <= '0; f_j_r <= '0; f_rd_r <= 1'b0;
      end else if (cmd.fetch) begin
        if (f_i_r != f_n_r) f_i_r <= f_i_r + 3'd1;
        f_rd_r <= (f_i_r != f_n_r);
        if (f_rd_r) f_j_r <= f_j_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      p_sv_r <= sv; p_rv_r <= rv; p_dn_r <= dn; p_sb_r <= sb; p_rd_r <= rd;
      p_rc_r <= rc; p_st_r <= st; p_ab_r <= ab; f_n_r <= f_n; f_base_r <= f_base;
    end else if (cmd.fetch && f_rd_r) begin
      p_sb_r[8 + 8*f_j_r +: 8] <= rd_q;
    end
    if (cmd.finish) begin
      out_r <= {p_ab_r, p_st_r, p_dn_r, p_rc_r, p_rd_r, p_rv_r, p_sb_r,
                p_sv_r ? 11'(11'h600 + {4'd0, node_id}) : 11'd0, p_sv_r};
    end
  end

  assign result = out_r;

  `CHK_IMPL(a_idle_start, clk, rst_n, cmd.eval && phase_r != PH_IDLE && opcode <= OP_WR_SEG, !sv)
  `CHK_IMPL(a_fetch_ph, clk, rst_n, cmd.fetch, phase_r == PH_WR_SEG)
  `CHK_IMPL(a_fetch_cnt, clk, rst_n, cmd.fetch, f_i_r <= f_n_r)
endmodule

/* sv/sdo_client_transfer_engine_core.sv */
// SDO client transfer engine. Each input transfer (a start, a store load, a reply
// or a timeout) yields exactly one result transfer. For most items the accepting
// edge evaluates the item and the result register is written from the output state
// once the output register is free, after which the next item can be taken. A reply
// that launches a segmented write segment reads its up to seven data bytes from the
// write store, one per cycle through a single registered read port, before the
// result register is written. A result still waiting in the output register holds
// back the following item's result until the output side takes it. The write
// store has no reset; a byte must be loaded before a segment sends it.
// Configuration writes (0 node_id, 1 max_segments, 2 spy_mode) are always ready.
module sdo_client_transfer_engine_core
  import sdo_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // opcode, object_index, object_subindex, write_word, write_count,
  // write_length, load_position, load_byte, reply_bytes, reply_length
  input  logic [167:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // send_valid, send_identifier, send_bytes, read_valid, read_bytes,
  // read_count, done_res, status, abort_code
  output logic [175:0]  out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [6:0]  node_r;
  logic [15:0] maxs_r;
  logic        spy_r;
  logic [172:0] res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= 7'd1; maxs_r <= 16'd1024; spy_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NODE: node_r <= cfg_data[6:0];
        CFG_MAXS: maxs_r <= cfg_data;
        CFG_SPY:  spy_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sdo_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tready, .out_tvalid, .sts, .cmd
  );

  sdo_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .opcode(in_tdata[2:0]), .object_index(in_tdata[18:3]),
    .object_subindex(in_tdata[26:19]), .write_word(in_tdata[58:27]),
    .write_count(in_tdata[61:59]), .write_length(in_tdata[73:62]),
    .load_position(in_tdata[84:74]), .load_byte(in_tdata[92:85]),
    .reply_bytes(in_tdata[156:93]), .reply_length(in_tdata[160:157]),
    .node_id(node_r), .max_segments(maxs_r), .spy_mode(spy_r), .result(res)
  );

  assign out_tdata = {3'd0, res};
endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sdo_pkg::*;

  localparam int STORE_DEPTH = WRITE_STORE_DEPTH;

  // Input item, last field in the lowest bits once packed.
  typedef struct packed {
    logic [3:0]  reply_length;
    logic [63:0] reply_bytes;
    logic [7:0]  load_byte;
    logic [10:0] load_position;
    logic [11:0] write_length;
    logic [2:0]  write_count;
    logic [31:0] write_word;
    logic [7:0]  object_subindex;
    logic [15:0] object_index;
    logic [2:0]  opcode;
  } sdo_item_t;

  // Result item, same packing rule.
  typedef struct packed {
    logic [31:0] abort_code;
    logic [3:0]  status;
    logic        done_res;
    logic [2:0]  read_count;
    logic [55:0] read_bytes;
    logic        read_valid;
    logic [63:0] send_bytes;
    logic [10:0] send_identifier;
    logic        send_valid;
  } sdo_result_t;

  // Client behavior mirror plus the queue of results still owed by the block.
  class sdo_scoreboard;
    bit [6:0]    node = 7'd1;
    bit [15:0]   seg_limit = 16'd1024;
    bit          spy = 1'b1;
    phase_t      ph = PH_IDLE;
    bit          tg;
    bit [15:0]   segs;
    bit [15:0]   hidx;
    bit [7:0]    hsub;
    bit [11:0]   total;
    bit [11:0]   sent;
    bit [7:0]    store [STORE_DEPTH];
    sdo_result_t pending [$];
    int          errors;
    int          checked;

    function bit [63:0] obj_field();
      return (64'(hidx) << 8) | (64'(hsub) << 24);
    endfunction

    function bit [11:0] chunk_len();
      bit [11:0] left;
      left = (total > sent) ? total - sent : 12'd0;
      return (left < 12'd7) ? left : 12'd7;
    endfunction

    function bit [63:0] segment_frame();
      bit [11:0] left;
      bit [11:0] n;
      bit [63:0] f;
      left = (total > sent) ? total - sent : 12'd0;
      n = chunk_len();
      f = 64'((tg << 4) | ((7 - n) << 1) | (left <= 7 ? 1 : 0));
      for (int i = 0; i < n; i++)
        f |= 64'(store[sent + i]) << (8 * (i + 1));
      return f;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_NODE: node = val[6:0];
        CFG_MAXS: seg_limit = val;
        CFG_SPY:  spy = val[0];
        default: ;
      endcase
    endfunction

    // Advance the mirror by one accepted input and queue what it yields.
    function void note_input(sdo_item_t it);
      sdo_result_t r;
      bit [63:0] sb;
      bit [7:0]  b0;
      int        n;
      bit [11:0] len;
      r = '0;
      sb = '0;
      b0 = it.reply_bytes[7:0];
      if (it.opcode <= OP_WR_SEG && ph == PH_IDLE) begin
        hidx = it.object_index;
        hsub = it.object_subindex;
        tg = 0; segs = 0; sent = 0;
        if (it.opcode == OP_READ) begin
          sb = 64'h40 | obj_field(); r.send_valid = 1; ph = PH_RD_INIT;
        end else if (it.opcode == OP_WR_EXP) begin
          n = it.write_count;
          if (n < 1) n = 1;
          if (n > 4) n = 4;
          sb = 64'(8'h23 | ((4 - n) << 2)) | obj_field();
          for (int i = 0; i < n; i++)
            sb |= 64'(it.write_word[8*i +: 8]) << (8 * (4 + i));
          r.send_valid = 1; ph = PH_WR_EXP;
        end else begin
          len = it.write_length;
          if (len > STORE_DEPTH) len = STORE_DEPTH;
          if (len == 0) begin
            r.done_res = 1; r.status = ST_HEADER;
          end else begin
            total = len;
            sb = 64'h21 | obj_field() | (64'(len) << 32);
            r.send_valid = 1; ph = PH_WR_INIT;
          end
        end
      end else if (it.opcode == OP_LOAD) begin
        store[it.load_position] = it.load_byte;
      end else if (it.opcode == OP_TMO) begin
        if (ph != PH_IDLE) begin
          r.done_res = 1; r.status = ST_TIMEOUT; ph = PH_IDLE;
        end
      end else if (it.opcode == OP_REPLY && !spy) begin
        if (ph == PH_IDLE) begin
          r.status = ST_UNEXP;
        end else if (b0 == 8'h80) begin
          r.status = ST_ABORT; r.abort_code = it.reply_bytes[63:32];
        end else if (it.reply_length != 4'd8) begin
          r.status = ST_LEN;
        end else if ((ph == PH_RD_INIT || ph == PH_WR_EXP || ph == PH_WR_INIT) &&
                     ((it.reply_bytes & 64'hffffff00) != obj_field())) begin
          r.status = ST_OBJ;
        end else if (ph == PH_RD_INIT) begin
          if (b0[1]) begin
            if (!b0[0]) begin
              r.status = ST_SIZE;
            end else begin
              r.read_count = 3'(4 - b0[3:2]);
              for (int i = 0; i < r.read_count; i++)
                r.read_bytes[8*i +: 8] = it.reply_bytes[8*(4+i) +: 8];
              r.read_valid = 1; r.status = ST_OK;
            end
          end else begin
            tg = 0; segs = 0;
            sb = 64'h60; r.send_valid = 1; ph = PH_RD_SEG;
          end
        end else if (ph == PH_RD_SEG) begin
          if (b0[4] != tg) begin
            r.status = ST_TOGGLE;
          end else begin
            r.read_count = 3'(7 - b0[3:1]);
            for (int i = 0; i < r.read_count; i++)
              r.read_bytes[8*i +: 8] = it.reply_bytes[8*(1+i) +: 8];
            r.read_valid = 1;
            tg ^= 1; segs++;
            if (segs >= seg_limit) r.status = ST_SEGS;
            else if (b0[0]) r.status = ST_OK;
            else begin sb = 64'(8'h60 | (tg << 4)); r.send_valid = 1; end
          end
        end else if (ph == PH_WR_EXP) begin
          r.status = (b0 == 8'h60) ? ST_OK : ST_HEADER;
        end else if (ph == PH_WR_INIT) begin
          tg = 0; segs = 0; sent = 0;
          sb = segment_frame(); r.send_valid = 1; ph = PH_WR_SEG;
        end else begin
          if (b0 != (8'h20 | (tg << 4))) begin
            r.status = ST_HEADER;
          end else begin
            sent = sent + chunk_len();
            tg ^= 1; segs++;
            if (segs >= seg_limit) r.status = ST_SEGS;
            else if (sent >= total) r.status = ST_OK;
            else begin sb = segment_frame(); r.send_valid = 1; end
          end
        end
        if (r.status != ST_NONE && r.status != ST_UNEXP) begin
          r.done_res = 1; ph = PH_IDLE;
        end
      end
      if (r.send_valid) begin
        r.send_identifier = 11'h600 + node;
        r.send_bytes = sb;
      end
      pending.push_back(r);
    endfunction

    // Compare one result transfer with the oldest owed result.
    function void check_result(logic [175:0] raw);
      sdo_result_t got;
      sdo_result_t want;
      got = raw[$bits(sdo_result_t)-1:0];
      if (pending.size() == 0) begin
        $display("%0t: result with nothing owed, got %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.send_valid !== want.send_valid)
        $display("%0t: send_valid exp %h got %h", $time, want.send_valid, got.send_valid);
      if (got.send_identifier !== want.send_identifier)
        $display("%0t: send_identifier exp %h got %h", $time,
                 want.send_identifier, got.send_identifier);
      if (got.send_bytes !== want.send_bytes)
        $display("%0t: send_bytes exp %h got %h", $time, want.send_bytes, got.send_bytes);
      if (got.read_valid !== want.read_valid)
        $display("%0t: read_valid exp %h got %h", $time, want.read_valid, got.read_valid);
      if (got.read_bytes !== want.read_bytes)
        $display("%0t: read_bytes exp %h got %h", $time, want.read_bytes, got.read_bytes);
      if (got.read_count !== want.read_count)
        $display("%0t: read_count exp %h got %h", $time, want.read_count, got.read_count);
      if (got.done_res !== want.done_res)
        $display("%0t: done_res exp %h got %h", $time, want.done_res, got.done_res);
      if (got.status !== want.status)
        $display("%0t: status exp %h got %h", $time, want.status, got.status);
      if (got.abort_code !== want.abort_code)
        $display("%0t: abort_code exp %h got %h", $time, want.abort_code, got.abort_code);
      if (got !== want) errors++;
    endfunction
  endclass

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_tvalid = 0;
  logic          in_tready;
  logic [167:0]  in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 0;
  logic [175:0]  out_tdata;
  logic          cfg_valid = 0;
  logic          cfg_ready;
  logic [1:0]    cfg_index = '0;
  logic [15:0]   cfg_data = '0;

  sdo_scoreboard sb = new();
  bit            loaded [STORE_DEPTH];
  bit            calm;
  int            n_items;
  int            n_segwrites;

  always #2 clk = ~clk;

  sdo_client_transfer_engine_core dut (.*);

  // Result side: random back-pressure, checks on each completed transfer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= calm || ($urandom_range(99) >= 12);
  end

  task automatic drive(sdo_item_t it);
    logic [167:0] flat;
    if (!calm && $urandom_range(99) < 12) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    flat = 168'(it);
    sb.note_input(it);
    in_tvalid <= 1;
    in_tdata <= flat;
    do @(posedge clk); while (!in_tready);
    n_items++;
  endtask

  function automatic sdo_item_t rand_item();
    sdo_item_t it;
    it.opcode = 3'($urandom);
    it.object_index = 16'($urandom);
    it.object_subindex = 8'($urandom);
    it.write_word = $urandom;
    it.write_count = 3'($urandom);
    it.write_length = 12'($urandom);
    it.load_position = 11'($urandom);
    it.load_byte = 8'($urandom);
    it.reply_bytes = {$urandom, $urandom};
    it.reply_length = 4'($urandom);
    return it;
  endfunction

  task automatic load_at(int pos);
    sdo_item_t it;
    it = rand_item();
    it.opcode = OP_LOAD;
    it.load_position = 11'(pos);
    drive(it);
    loaded[pos] = 1;
  endtask

  // Build a reply that fits the current phase; with broken set, spoil one part of it.
  function automatic sdo_item_t make_reply(bit broken);
    sdo_item_t it;
    bit [7:0] b0;
    bit [63:0] objf;
    int n;
    it = rand_item();
    it.opcode = OP_REPLY;
    it.reply_length = 4'd8;
    objf = sb.obj_field();
    it.reply_bytes[31:8] = objf[31:8];
    case (sb.ph)
      PH_RD_INIT: begin
        if ($urandom_range(1)) begin
          n = $urandom_range(1, 4);
          b0 = 8'h42 | 8'((4 - n) << 2) | 8'($urandom_range(5) != 0);
        end else begin
          b0 = 8'h40 | 8'($urandom_range(1));
        end
      end
      PH_RD_SEG:  b0 = 8'(sb.tg << 4) | 8'($urandom_range(7) << 1) |
                       8'($urandom_range(5) == 0);
      PH_WR_SEG:  b0 = 8'h20 | 8'(sb.tg << 4);
      default:    b0 = 8'h60;
    endcase
    if (broken) begin
      case ($urandom_range(4))
        0: it.reply_length = 4'($urandom);
        1: b0 = 8'h80;
        2: it.reply_bytes[31:8] ^= 24'(1 << $urandom_range(23));
        3: b0 ^= 8'h10;
        default: b0 = 8'($urandom);
      endcase
    end
    it.reply_bytes[7:0] = b0;
    return it;
  endfunction

  // One transfer from start to end: kind is the start opcode.
  task automatic run_flow(logic [2:0] kind, int len, int broken_pct);
    sdo_item_t it;
    int eff;
    if (kind == OP_WR_SEG) begin
      eff = (len > STORE_DEPTH) ? STORE_DEPTH : len;
      for (int p = 0; p < eff; p++) if (!loaded[p]) load_at(p);
      n_segwrites++;
    end
    it = rand_item();
    it.opcode = kind;
    it.write_length = 12'(len);
    drive(it);
    while (sb.ph != PH_IDLE) begin
      case ($urandom_range(99))
        0, 1: begin it = rand_item(); it.opcode = OP_TMO; drive(it); end
        2, 3: begin it = rand_item(); it.opcode = 3'($urandom_range(2)); drive(it); end
        4, 5: load_at($urandom_range(STORE_DEPTH - 1));
        default: drive(make_reply($urandom_range(99) < broken_pct));
      endcase
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic setup(logic [6:0] node, logic [15:0] limit, bit spy);
    in_tvalid <= 0;
    write_reg(CFG_NODE, 16'(node));
    write_reg(CFG_MAXS, limit);
    write_reg(CFG_SPY, 16'(spy));
  endtask

  task automatic one_item(logic [2:0] op);
    sdo_item_t it;
    it = rand_item();
    it.opcode = op;
    drive(it);
  endtask

  task automatic random_phase(int count);
    int start;
    int pick;
    start = n_items;
    while (n_items - start < count) begin
      pick = $urandom_range(99);
      if (pick < 30) run_flow(OP_READ, 0, 15);
      else if (pick < 50) run_flow(OP_WR_EXP, 0, 15);
      else if (pick < 80)
        run_flow(OP_WR_SEG, ($urandom_range(29) == 0) ? $urandom_range(41, 200)
                                                      : $urandom_range(1, 40), 15);
      else one_item(3'($urandom_range(3, 7)));
    end
  endtask

  initial begin
    sdo_item_t it;
    int guard;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Spy mode is on out of reset: replies must be ignored.
    one_item(OP_READ);
    drive(make_reply(0));
    one_item(OP_TMO);

    setup(7'd1, 16'd1024, 1'b0);
    calm = 1;
    // Directed: idle reply, idle timeout, the unused opcodes.
    one_item(OP_REPLY);
    one_item(OP_TMO);
    one_item(3'd6);
    one_item(3'd7);
    // Expedited write of every byte count, including the clipped ones.
    for (int c = 0; c < 8; c++) begin
      it = rand_item();
      it.opcode = OP_WR_EXP;
      it.write_count = 3'(c);
      it.write_word = (c & 1) ? 32'hffffffff : 32'h0;
      it.object_index = (c & 1) ? 16'hffff : 16'h0;
      it.object_subindex = (c & 1) ? 8'hff : 8'h0;
      drive(it);
      drive(make_reply(0));
    end
    // Abort with a short frame still carries the abort code.
    one_item(OP_READ);
    it = make_reply(0);
    it.reply_bytes[7:0] = 8'h80;
    it.reply_length = 4'd3;
    drive(it);
    // Start while busy, then a timeout ends the wait.
    one_item(OP_WR_EXP);
    one_item(OP_READ);
    one_item(OP_TMO);
    // Segmented write of length zero, then the longest one (clipped to the store),
    // which sends its first two segments and is then ended by a timeout.
    it = rand_item();
    it.opcode = OP_WR_SEG;
    it.write_length = 12'd0;
    drive(it);
    for (int p = 0; p < 14; p++) if (!loaded[p]) load_at(p);
    it = rand_item();
    it.opcode = OP_WR_SEG;
    it.write_length = 12'd4095;
    drive(it);
    drive(make_reply(0));
    drive(make_reply(0));
    one_item(OP_TMO);
    run_flow(OP_READ, 0, 0);
    calm = 0;

    random_phase(400);
    setup(7'd127, 16'd1, 1'b0);
    random_phase(250);
    setup(7'd64, 16'd65535, 1'b0);
    random_phase(350);
    setup(7'd5, 16'd3, 1'b0);
    calm = 1;
    random_phase(200);
    calm = 0;
    setup(7'd33, 16'd1024, 1'b1);
    random_phase(60);
    setup(7'd9, 16'd200, 1'b0);
    random_phase(150);

    in_tvalid <= 0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("Drove %0d input transfers, %0d segmented writes, checked %0d results.",
             n_items, n_segwrites, sb.checked);
    if (sb.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #40ms;
    $display("Run timed out.");
    $display("tb_top: errors");
    $finish;
  end

endmodule
